// ----- hw/rtl/sse_pkg.sv -----
// Shared types and constants for the sorted set engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package sse_pkg;

   // Operation carried in the request tuser field.
   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_ERASE  = 2'd1,
      KIND_LOOKUP = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   // Commands that the controller hands to the datapath, one per cycle.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_PROBE,
      OP_COMPARE,
      OP_SETUP,
      OP_MOVE_RD,
      OP_MOVE_WR,
      OP_COMMIT,
      OP_CLEAR,
      OP_REFUSE,
      OP_EDGE_RD,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      ready;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     taken;
      logic     search_open;
      logic     hit;
      logic     full;
      logic     move_more;
      logic     rsp_free;
   } dp_status_type;

   localparam int KIND_W      = 2;
   localparam int REQ_TDATA_W = 32;
   localparam int OUT_VALUE_W = 32;
   localparam int COUNT_W     = 7;
   localparam int RSP_FIELD_W = 3 + COUNT_W + 2 * OUT_VALUE_W;
   localparam int RSP_TDATA_W = 80;

endpackage

`default_nettype wire

// ----- hw/rtl/sse_control.sv -----
// Controller state machine of the sorted set engine.
// Sequences search, entry moves and result delivery; uses sse_pkg.
`default_nettype none

module sse_control
   import sse_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEEK,
      ST_PROBE,
      ST_COMPARE,
      ST_SETUP,
      ST_MOVE_CHK,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_COMMIT,
      ST_CLEAR,
      ST_REFUSE,
      ST_EDGE,
      ST_RESPOND
   } state_type;

   state_type  state_ff, state_in;
   dp_cmd_type cmd_ff, cmd_in;

   // The command register always carries the command of the state held.
   always_comb begin
      state_in     = state_ff;
      cmd_in.op    = OP_NOP;
      cmd_in.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // A beat taken in idle starts the search.
            if (status.taken) begin
               state_in = ST_SEEK;
            end else begin
               cmd_in.ready = 1'b1;
            end
         end
         ST_SEEK: begin
            if (status.search_open) begin
               state_in  = ST_PROBE;
               cmd_in.op = OP_PROBE;
            end else if (status.kind == KIND_CLEAR) begin
               state_in  = ST_CLEAR;
               cmd_in.op = OP_CLEAR;
            end else if (status.kind == KIND_INSERT && !status.hit) begin
               if (status.full) begin
                  state_in  = ST_REFUSE;
                  cmd_in.op = OP_REFUSE;
               end else begin
                  state_in  = ST_SETUP;
                  cmd_in.op = OP_SETUP;
               end
            end else if (status.kind == KIND_ERASE && status.hit) begin
               state_in  = ST_SETUP;
               cmd_in.op = OP_SETUP;
            end else begin
               state_in  = ST_EDGE;
               cmd_in.op = OP_EDGE_RD;
            end
         end
         ST_PROBE: begin
            state_in  = ST_COMPARE;
            cmd_in.op = OP_COMPARE;
         end
         ST_COMPARE: state_in = ST_SEEK;
         ST_SETUP:   state_in = ST_MOVE_CHK;
         ST_MOVE_CHK: begin
            if (status.move_more) begin
               state_in  = ST_MOVE_RD;
               cmd_in.op = OP_MOVE_RD;
            end else begin
               state_in  = ST_COMMIT;
               cmd_in.op = OP_COMMIT;
            end
         end
         ST_MOVE_RD: begin
            state_in  = ST_MOVE_WR;
            cmd_in.op = OP_MOVE_WR;
         end
         ST_MOVE_WR: state_in = ST_MOVE_CHK;
         ST_COMMIT, ST_CLEAR, ST_REFUSE: begin
            state_in  = ST_EDGE;
            cmd_in.op = OP_EDGE_RD;
         end
         ST_EDGE: begin
            state_in  = ST_RESPOND;
            cmd_in.op = OP_EMIT;
         end
         ST_RESPOND: begin
            if (status.rsp_free) begin
               state_in     = ST_IDLE;
               cmd_in.ready = 1'b1;
            end else begin
               cmd_in.op = OP_EMIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff.op    <= OP_NOP;
         cmd_ff.ready <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sse_datapath.sv -----
// Datapath of the sorted set engine: sorted store memory, search bounds,
// count, move index and the result register. Uses sse_pkg.
`default_nettype none

module sse_datapath
   import sse_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   output dp_status_type               status,
   input  wire logic                   req_tvalid,
   input  wire logic [KIND_W-1:0]      req_tuser,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tvalid,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (VALUE_BITS > OUT_VALUE_W) ? VALUE_BITS : OUT_VALUE_W;
   localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

   logic [VALUE_BITS-1:0] store_mem [CAPACITY];

   kind_type              kind_ff, kind_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [CW-1:0]         lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW-1:0]         mv_ff, mv_in, count_ff, count_in;
   logic                  eq_ff, eq_in, refused_ff, refused_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [VALUE_BITS-1:0] rda_ff, rdb_ff;

   logic                  load, is_ins, rsp_free, empty;
   logic [CW-1:0]         mid, rda_idx;
   logic                  rda_en, rdb_en, wr_en;
   logic [AW-1:0]         wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [EW-1:0]         min_wide, max_wide;
   logic [OUT_VALUE_W-1:0] min_out, max_out;

   assign load     = cmd.ready & req_tvalid;
   assign is_ins   = (kind_ff == KIND_INSERT);
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign empty    = (count_ff == '0);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);

   // Memory port control.
   always_comb begin
      rda_en  = 1'b0;
      rdb_en  = 1'b0;
      rda_idx = '0;
      wr_en   = 1'b0;
      wr_addr = mv_ff[AW-1:0];
      wr_data = rda_ff;
      case (cmd.op)
         OP_PROBE: begin
            rda_en  = 1'b1;
            rda_idx = mid;
         end
         OP_MOVE_RD: begin
            rda_en  = 1'b1;
            rda_idx = is_ins ? (mv_ff - 1'b1) : (mv_ff + 1'b1);
         end
         OP_MOVE_WR: wr_en = 1'b1;
         OP_COMMIT: begin
            if (is_ins) begin
               wr_en   = 1'b1;
               wr_addr = lo_ff[AW-1:0];
               wr_data = value_ff;
            end
         end
         OP_EDGE_RD: begin
            rda_en = 1'b1;
            rdb_en = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rda_en) begin
         rda_ff <= store_mem[rda_idx[AW-1:0]];
      end
      if (rdb_en) begin
         rdb_ff <= store_mem[AW'(count_ff - 1'b1)];
      end
   end

   assign min_wide = EW'(rda_ff);
   assign max_wide = EW'(rdb_ff);
   assign min_out  = empty ? '0 : min_wide[OUT_VALUE_W-1:0];
   assign max_out  = empty ? '0 : max_wide[OUT_VALUE_W-1:0];

   always_comb begin
      kind_in      = kind_ff;
      value_in     = value_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      mv_in        = mv_ff;
      count_in     = count_ff;
      eq_in        = eq_ff;
      refused_in   = refused_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         kind_in    = kind_type'(req_tuser);
         value_in   = VALUE_BITS'(req_tdata);
         lo_in      = '0;
         hi_in      = (kind_type'(req_tuser) == KIND_CLEAR) ? '0 : count_ff;
         eq_in      = 1'b0;
         refused_in = 1'b0;
      end
      case (cmd.op)
         OP_PROBE: mid_in = mid;
         OP_COMPARE: begin
            if (rda_ff < value_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               // The last upper-bound probe is the insertion point itself.
               hi_in = mid_ff;
               eq_in = (rda_ff == value_ff);
            end
         end
         OP_SETUP:   mv_in = is_ins ? count_ff : lo_ff;
         OP_MOVE_WR: mv_in = is_ins ? (mv_ff - 1'b1) : (mv_ff + 1'b1);
         OP_COMMIT:  count_in = is_ins ? (count_ff + 1'b1) : (count_ff - 1'b1);
         OP_CLEAR:   count_in = '0;
         OP_REFUSE:  refused_in = 1'b1;
         OP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_TDATA_W - RSP_FIELD_W)'(0), max_out, min_out,
                               empty, COUNT_W'(count_ff), refused_ff, eq_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      value_ff    <= value_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      mv_ff       <= mv_in;
      eq_ff       <= eq_in;
      refused_ff  <= refused_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.kind        = kind_ff;
   assign status.taken       = load;
   assign status.search_open = (lo_ff < hi_ff);
   assign status.hit         = eq_ff;
   assign status.full        = (count_ff == CapCount);
   assign status.move_more   = is_ins ? (mv_ff > lo_ff) : ((mv_ff + 1'b1) < count_ff);
   assign status.rsp_free    = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_set_engine.sv -----
// Sorted set engine: a bounded set of distinct values kept in ascending order.
// Each request is an insert, erase, lookup or clear; each yields one response
// beat with found, refused_full, element count, empty flag, minimum and maximum.
// Requests enter on the req_ stream (kind in tuser, value in tdata), responses
// leave on the rsp_ stream from an output register.
// One request is in work at a time. Its search makes at most
// floor(log2(count)) + 1 binary search probes on the single-ported search read
// of the store memory; req_tready rises again in the same cycle as the response
// becomes valid. A clear or a refused insert passes through its own clear or
// refuse state. An insert of a new value or an erase of a present one moves up
// to CAPACITY-1 entries one at a time through that same memory port.
// A waiting response never blocks the work on the following request; only the
// hand-off of the next response waits for rsp_tready.
// Reset (synchronous) empties the set and drops any held response; req_tready
// is low during reset and rises in the cycle after it is released. The store
// memory is not cleared; values past the count never reach a response.
`default_nettype none

module sorted_set_engine
   import sse_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] value
   input  wire logic [KIND_W-1:0]      req_tuser,  // [1:0] kind
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] found, [1] refused_full, [8:2] element_count, [9] is_empty,
   // [41:10] min_value, [73:42] max_value, [79:74] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   sse_control u_control (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   sse_datapath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_tready = cmd.ready;

endmodule

`default_nettype wire

// ----- hw/rtl/sse_checker.sv -----
// Port-level checker for the sorted set engine, bound to the top level.
// Uses sse_pkg for field widths.
`default_nettype none

module sse_checker
   import sse_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 32
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic                   found, refused, empty;
   logic [COUNT_W-1:0]     count;
   logic [OUT_VALUE_W-1:0] min_v, max_v;

   assign found   = rsp_tdata[0];
   assign refused = rsp_tdata[1];
   assign count   = rsp_tdata[8:2];
   assign empty   = rsp_tdata[9];
   assign min_v   = rsp_tdata[41:10];
   assign max_v   = rsp_tdata[73:42];

   // A stalled response beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // Only one request is in work: no request is taken right after another.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in work");

   // The empty flag agrees with the count and forces zero bounds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (CAPACITY > 127) ||
                     ((empty == (count == '0)) && (!empty || (min_v == '0 && max_v == '0))))
      else $error("empty flag inconsistent with count or bounds");

   // The set is sorted, so the minimum never exceeds the maximum.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !empty |-> (VALUE_BITS > OUT_VALUE_W) || (min_v <= max_v))
      else $error("minimum above maximum");

   // A refused insert means a new value met a full store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && refused |-> !found && ((CAPACITY > 127) || (count == COUNT_W'(CAPACITY))))
      else $error("refused insert without a full store");

endmodule

bind sorted_set_engine sse_checker #(
   .CAPACITY   (CAPACITY),
   .VALUE_BITS (VALUE_BITS)
) u_sse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
